### rtl/amu_pkg.sv
// ----------------------------------------------------------------------------
// amu_pkg
// Shared types and codes for the affine matrix unit: transaction structs,
// command and status codes, matrix entry indices.
// ----------------------------------------------------------------------------
package amu_pkg;

	// coefficient width and internal wide-value width
	localparam int CW = 32;
	localparam int VW = 66;

	// command queue depth between front and back
	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// command codes on the input port
	localparam logic [2:0] CMD_LOAD  = 3'd0;
	localparam logic [2:0] CMD_IDENT = 3'd1;
	localparam logic [2:0] CMD_PRE   = 3'd2;
	localparam logic [2:0] CMD_POST  = 3'd3;
	localparam logic [2:0] CMD_TRANS = 3'd4;
	localparam logic [2:0] CMD_INV   = 3'd5;
	localparam logic [2:0] CMD_READ  = 3'd6;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_SINGULAR = 2'd1;
	localparam logic [1:0] STAT_SAT      = 2'd2;

	// matrix entry indices
	localparam logic [2:0] IXX = 3'd0;
	localparam logic [2:0] IXY = 3'd1;
	localparam logic [2:0] IYX = 3'd2;
	localparam logic [2:0] IYY = 3'd3;
	localparam logic [2:0] IX0 = 3'd4;
	localparam logic [2:0] IY0 = 3'd5;

	// classified operation carried through the queue
	typedef enum logic [2:0] {
		OP_LOAD,
		OP_IDENT,
		OP_PRE,
		OP_POST,
		OP_TRANS,
		OP_INV,
		OP_READ
	} op_t;

	typedef struct packed {
		logic [2:0]           command;
		logic signed [CW-1:0] coef_xx;
		logic signed [CW-1:0] coef_xy;
		logic signed [CW-1:0] coef_yx;
		logic signed [CW-1:0] coef_yy;
		logic signed [CW-1:0] coef_x0;
		logic signed [CW-1:0] coef_y0;
	} cmd_item_t;

	typedef struct packed {
		logic signed [CW-1:0] out_xx;
		logic signed [CW-1:0] out_xy;
		logic signed [CW-1:0] out_yx;
		logic signed [CW-1:0] out_yy;
		logic signed [CW-1:0] out_x0;
		logic signed [CW-1:0] out_y0;
		logic [1:0]           status;
	} rsp_item_t;

	// queue entry: operation plus operand matrix indexed by IXX..IY0
	typedef struct packed {
		op_t               op;
		logic [5:0][CW-1:0] coef;
	} q_item_t;

endpackage

### rtl/affine_matrix_unit.sv
// ----------------------------------------------------------------------------
// affine_matrix_unit
// 2D affine matrix unit: load, identity, pre/post multiply, translate,
// invert and read on one held Q16.16 matrix.
// ----------------------------------------------------------------------------
// Each command transaction returns one response carrying the matrix after
// the command and a status. Commands queue two deep ahead of a back end
// that works on one command at a time. Load, identity and read need no
// products; multiply and translate run twelve products through one shared
// 32x32 multiplier; invert runs six products and then six passes of the
// bit-serial divider. A singular invert finishes after the products. A
// stalled response holds the back end until it is taken.
module affine_matrix_unit import amu_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	logic    q_valid;
	logic    q_pop;
	q_item_t q_item;

	// command intake and queue
	amu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item)
	);

	// matrix engine and response register
	amu_engine #(
		.FRAC_BITS (FRAC_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

### rtl/amu_front.sv
// ----------------------------------------------------------------------------
// amu_front
// Accepts command transactions, decodes the command into an operation and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module amu_front import amu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd,
	output logic      q_valid,
	input  logic      q_pop,
	output q_item_t   q_item
);

	q_item_t          fifo_q [QDEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;
	q_item_t          enc;
	logic             push;

	// classify the command
	always_comb begin
		enc = '0;
		case (cmd.command)
			CMD_LOAD:  enc.op = OP_LOAD;
			CMD_IDENT: enc.op = OP_IDENT;
			CMD_PRE:   enc.op = OP_PRE;
			CMD_POST:  enc.op = OP_POST;
			CMD_TRANS: enc.op = OP_TRANS;
			CMD_INV:   enc.op = OP_INV;
			default:   enc.op = OP_READ;
		endcase
		enc.coef[IXX] = cmd.coef_xx;
		enc.coef[IXY] = cmd.coef_xy;
		enc.coef[IYX] = cmd.coef_yx;
		enc.coef[IYY] = cmd.coef_yy;
		enc.coef[IX0] = cmd.coef_x0;
		enc.coef[IY0] = cmd.coef_y0;
	end

	assign cmd_ready = (count_q != QCW'(QDEPTH));
	assign push      = cmd_valid && cmd_ready;
	assign q_valid   = (count_q != '0);
	assign q_item    = fifo_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= enc;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/amu_div.sv
// ----------------------------------------------------------------------------
// amu_div
// Iterative signed divider, one quotient bit per cycle. Quotient truncates
// toward zero and is saturated to 32 bits with a flag.
// ----------------------------------------------------------------------------
module amu_div import amu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [VW-1:0] num,
	input  logic signed [VW-1:0] den,
	output logic                 done,
	output logic signed [CW-1:0] quo,
	output logic                 sat
);

	localparam int DSW = VW + CW + 1;
	localparam int SCW = $clog2(CW + 2);

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_FIN
	} dv_state_t;

	dv_state_t       state_q;
	logic [VW-1:0]   rem_q;
	logic [DSW-1:0]  dsh_q;
	logic [CW:0]     qmag_q;
	logic            neg_q;
	logic [SCW-1:0]  step_q;
	logic [VW-1:0]   nmag;
	logic [VW-1:0]   dmag;
	logic [DSW-1:0]  rem_x;
	logic            take;

	assign nmag  = num[VW-1] ? VW'(-num) : VW'(num);
	assign dmag  = den[VW-1] ? VW'(-den) : VW'(den);
	assign rem_x = DSW'(rem_q);
	assign take  = (rem_x >= dsh_q);

	// restoring division, quotient bit CW first as overflow detect
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			step_q  <= '0;
			rem_q   <= '0;
			dsh_q   <= '0;
			qmag_q  <= '0;
			neg_q   <= 1'b0;
		end else begin
			case (state_q)
				DV_IDLE: begin
					if (start) begin
						rem_q   <= nmag;
						dsh_q   <= DSW'(dmag) << CW;
						qmag_q  <= '0;
						neg_q   <= num[VW-1] ^ den[VW-1];
						step_q  <= '0;
						state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					if (take) begin
						rem_q <= VW'(rem_x - dsh_q);
					end
					qmag_q <= {qmag_q[CW-1:0], take};
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q + 1'b1;
					if (step_q == SCW'(CW)) begin
						state_q <= DV_FIN;
					end
				end
				DV_FIN: begin
					state_q <= DV_IDLE;
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	assign done = (state_q == DV_FIN);

	// sign and saturate
	always_comb begin
		sat = 1'b0;
		quo = $signed(qmag_q[CW-1:0]);
		if (qmag_q[CW]) begin
			sat = 1'b1;
			quo = neg_q ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else if (neg_q) begin
			if (qmag_q[CW-1] && (qmag_q[CW-2:0] != '0)) begin
				sat = 1'b1;
				quo = {1'b1, {(CW-1){1'b0}}};
			end else begin
				quo = -$signed(qmag_q[CW-1:0]);
			end
		end else if (qmag_q[CW-1]) begin
			sat = 1'b1;
			quo = {1'b0, {(CW-1){1'b1}}};
		end
	end

endmodule

### rtl/amu_engine.sv
// ----------------------------------------------------------------------------
// amu_engine
// Back end: holds the current matrix and carries out one operation at a
// time with a shared 32x32 multiplier and the iterative divider.
// ----------------------------------------------------------------------------
module amu_engine import amu_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_pop,
	input  q_item_t   q_item,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam logic signed [CW-1:0] ONE = CW'(64'(1) << FRAC_BITS);
	localparam logic [3:0] LAST_MUL = 4'd11;
	localparam logic [3:0] LAST_INV = 4'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_DONE
	} state_t;

	state_t                  state_q;
	op_t                     op_q;
	logic [3:0]              cnt_q;
	logic signed [CW-1:0]    cur_q [6];
	logic signed [CW-1:0]    opm_q [6];
	logic signed [CW-1:0]    t_q [6];
	logic signed [2*CW-1:0]  prod_q;
	logic signed [VW-1:0]    acc_q;
	logic signed [VW-1:0]    det_q;
	logic signed [VW-1:0]    nx_q;
	logic signed [VW-1:0]    ny_q;
	logic                    sat_q;
	logic                    sing_q;
	logic                    rsp_valid_q;
	rsp_item_t               rsp_q;

	logic [2:0]              e;
	logic                    k;
	logic [2:0]              a_idx;
	logic [2:0]              b_idx;
	logic [2:0]              cur_idx;
	logic [2:0]              opm_idx;
	logic                    a_from_cur;
	logic signed [CW-1:0]    cur_rd;
	logic signed [CW-1:0]    opm_rd;
	logic signed [CW-1:0]    op_a;
	logic signed [CW-1:0]    op_b;
	logic signed [VW-1:0]    prod_x;
	logic signed [VW-1:0]    sh;
	logic signed [VW-1:0]    sum;
	logic signed [VW-1:0]    num_sh;
	logic signed [VW-1:0]    div_num;
	logic                    div_start;
	logic                    div_done;
	logic signed [CW-1:0]    div_quo;
	logic                    div_sat;
	logic signed [CW-1:0]    nxt [6];
	logic                    commit;

	function automatic logic ovf32(logic signed [VW-1:0] v);
		return !((&v[VW-1:CW-1]) || !(|v[VW-1:CW-1]));
	endfunction

	function automatic logic signed [CW-1:0] clamp32(logic signed [VW-1:0] v);
		if (ovf32(v)) begin
			return v[VW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end
		return v[CW-1:0];
	endfunction

	// operand index selection for the current step
	always_comb begin
		e = cnt_q[3:1];
		k = cnt_q[0];
		case (e)
			IXX, IYX: a_idx = k ? IYX : IXX;
			IXY, IYY: a_idx = k ? IYY : IXY;
			default:  a_idx = k ? IY0 : IX0;
		endcase
		case (e)
			IXX, IXY, IX0: b_idx = k ? IXY : IXX;
			default:       b_idx = k ? IYY : IYX;
		endcase
		// invert products: det terms, then the offset numerators
		if (op_q == OP_INV) begin
			case (cnt_q[2:0])
				3'd0:    begin a_idx = IXX; b_idx = IYY; end
				3'd1:    begin a_idx = IYX; b_idx = IXY; end
				3'd2:    begin a_idx = IYY; b_idx = IX0; end
				3'd3:    begin a_idx = IXY; b_idx = IY0; end
				3'd4:    begin a_idx = IYX; b_idx = IX0; end
				default: begin a_idx = IXX; b_idx = IY0; end
			endcase
		end
		a_from_cur = !(op_q == OP_PRE || op_q == OP_TRANS);
		if (state_q == ST_MUL_B) begin
			cur_idx = e;
			opm_idx = e;
		end else begin
			cur_idx = a_from_cur ? a_idx : b_idx;
			opm_idx = a_from_cur ? b_idx : a_idx;
		end
		// divider numerator source for the diagonal and cross terms
		if (state_q == ST_DIV_GO) begin
			case (cnt_q[2:0])
				3'd0:    opm_idx = IYY;
				3'd1:    opm_idx = IXY;
				3'd2:    opm_idx = IYX;
				default: opm_idx = IXX;
			endcase
		end
	end

	assign cur_rd = cur_q[cur_idx];
	assign opm_rd = opm_q[opm_idx];
	assign op_a   = a_from_cur ? cur_rd : opm_rd;
	assign op_b   = a_from_cur ? opm_rd : cur_rd;
	assign prod_x = VW'(prod_q);
	assign sh     = prod_x >>> FRAC_BITS;
	assign sum    = acc_q + sh + ((e >= IX0) ? VW'(op_b) : VW'(0));
	assign num_sh = VW'(opm_rd) <<< FRAC_BITS;

	// numerator for the entry being divided
	always_comb begin
		case (cnt_q[2:0])
			3'd0, 3'd3: div_num = num_sh;
			3'd1, 3'd2: div_num = -num_sh;
			3'd4:       div_num = nx_q;
			default:    div_num = ny_q;
		endcase
	end

	assign div_start = (state_q == ST_DIV_GO) && (det_q != '0);

	amu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (det_q),
		.done   (div_done),
		.quo    (div_quo),
		.sat    (div_sat)
	);

	// matrix after the operation
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			case (op_q)
				OP_LOAD:                     nxt[i] = opm_q[i];
				OP_IDENT:                    nxt[i] = (i == 0 || i == 3) ? ONE : '0;
				OP_PRE, OP_POST, OP_TRANS:   nxt[i] = t_q[i];
				OP_INV:                      nxt[i] = sing_q ? cur_q[i] : t_q[i];
				default:                     nxt[i] = cur_q[i];
			endcase
		end
	end

	assign commit    = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < 6; i++) begin
				case (q_item.op)
					OP_TRANS: opm_q[i] <= (i == 0 || i == 3) ? ONE :
						(i >= 4) ? $signed(q_item.coef[i]) : '0;
					OP_INV:   opm_q[i] <= cur_q[i];
					default:  opm_q[i] <= $signed(q_item.coef[i]);
				endcase
			end
		end
		if (state_q == ST_MUL_A) begin
			prod_q <= op_a * op_b;
		end
		if (state_q == ST_MUL_B) begin
			if (op_q == OP_INV) begin
				case (cnt_q[2:0])
					3'd0:    det_q <= sh;
					3'd1:    det_q <= det_q - sh;
					3'd2:    nx_q  <= -prod_x;
					3'd3:    nx_q  <= nx_q + prod_x;
					3'd4:    ny_q  <= prod_x;
					default: ny_q  <= ny_q - prod_x;
				endcase
			end else if (!k) begin
				acc_q <= sh;
			end else begin
				t_q[e] <= clamp32(sum);
			end
		end
		if (state_q == ST_DIV_WAIT && div_done) begin
			t_q[cnt_q[2:0]] <= div_quo;
		end
		if (commit) begin
			rsp_q.out_xx <= nxt[0];
			rsp_q.out_xy <= nxt[1];
			rsp_q.out_yx <= nxt[2];
			rsp_q.out_yy <= nxt[3];
			rsp_q.out_x0 <= nxt[4];
			rsp_q.out_y0 <= nxt[5];
			rsp_q.status <= sing_q ? STAT_SINGULAR : (sat_q ? STAT_SAT : STAT_OK);
		end
	end

	// current matrix, identity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				cur_q[i] <= (i == 0 || i == 3) ? ONE : '0;
			end
		end else if (commit) begin
			for (int i = 0; i < 6; i++) begin
				cur_q[i] <= nxt[i];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_READ;
			cnt_q       <= '0;
			sat_q       <= 1'b0;
			sing_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						op_q   <= q_item.op;
						cnt_q  <= '0;
						sat_q  <= 1'b0;
						sing_q <= 1'b0;
						case (q_item.op)
							OP_PRE, OP_POST, OP_TRANS, OP_INV: state_q <= ST_MUL_A;
							default:                           state_q <= ST_DONE;
						endcase
					end
				end
				ST_MUL_A: state_q <= ST_MUL_B;
				ST_MUL_B: begin
					if (op_q != OP_INV && k && ovf32(sum)) begin
						sat_q <= 1'b1;
					end
					if (op_q == OP_INV && cnt_q == LAST_INV) begin
						cnt_q   <= '0;
						state_q <= ST_DIV_GO;
					end else if (op_q != OP_INV && cnt_q == LAST_MUL) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_MUL_A;
					end
				end
				ST_DIV_GO: begin
					if (det_q == '0) begin
						sing_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV_WAIT;
					end
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						if (div_sat) begin
							sat_q <= 1'b1;
						end
						if (cnt_q == LAST_INV) begin
							state_q <= ST_DONE;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a singular result only comes from invert and never carries saturation
	a_sing_inv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && sing_q) |-> (op_q == OP_INV && !sat_q))
		else $error("singular flag outside invert");

	// product counter stays within the composition schedule
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_A) |-> (cnt_q <= LAST_MUL))
		else $error("product counter out of range");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_WAIT))
		else $error("divider done while not waiting");

	// a finished division moves on to the next entry or to completion
	a_div_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_WAIT && div_done) |=>
		(state_q == ST_DIV_GO || state_q == ST_DONE))
		else $error("bad state after division");

endmodule
